FILE: rtl/hctbp_pkg.sv
// Types and constants shared by the code table bit packer modules.
package hctbp_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int MAX_CODE_LEN_DEF = 32;
  localparam int CODE_W = 32;
  localparam int LEN_W = 6;
  localparam int BYTE_W = 8;
  localparam int VBITS_W = 4;
  localparam int ACC_W = CODE_W + BYTE_W;
  localparam int CNT_W = 3;
  localparam int TOT_W = 6;
  localparam int NBYTES_W = 3;
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [7:0]        symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last;
  } result_t;

  typedef struct packed {
    logic table_clear;
    logic table_write;
    logic lookup;
    logic load;
    logic emit;
    logic commit;
    logic flush_out;
  } cmd_t;

  typedef struct packed {
    logic bytes_zero;
  } stat_t;

endpackage

FILE: rtl/hctbp_ctrl.sv
// Controller state machine for the code table bit packer.
module hctbp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          opcode,
  input  hctbp_pkg::stat_t    stat,
  output hctbp_pkg::cmd_t     cmd,
  output logic                busy
);

  hctbp_pkg::state_t state;
  hctbp_pkg::state_t state_next;
  hctbp_pkg::op_t    op;
  logic              take;

  assign op   = hctbp_pkg::op_t'(opcode);
  assign busy = (state != hctbp_pkg::ST_IDLE);
  assign take = start && (state == hctbp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hctbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hctbp_pkg::ST_IDLE: begin
        if (start) begin
          case (op)
            hctbp_pkg::OP_ENCODE: state_next = hctbp_pkg::ST_LOAD;
            hctbp_pkg::OP_FLUSH:  state_next = hctbp_pkg::ST_FLUSH;
            default:              state_next = hctbp_pkg::ST_IDLE;
          endcase
        end
      end
      hctbp_pkg::ST_LOAD:  state_next = hctbp_pkg::ST_EMIT;
      hctbp_pkg::ST_EMIT: begin
        if (stat.bytes_zero) begin
          state_next = hctbp_pkg::ST_IDLE;
        end
      end
      hctbp_pkg::ST_FLUSH: state_next = hctbp_pkg::ST_IDLE;
      default:             state_next = hctbp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      hctbp_pkg::ST_IDLE: begin
        cmd.table_clear = take && (op == hctbp_pkg::OP_CLEAR);
        cmd.table_write = take && (op == hctbp_pkg::OP_WRITE);
        cmd.lookup      = take && (op == hctbp_pkg::OP_ENCODE);
      end
      hctbp_pkg::ST_LOAD: cmd.load = 1'b1;
      hctbp_pkg::ST_EMIT: begin
        cmd.emit   = !stat.bytes_zero;
        cmd.commit = stat.bytes_zero;
      end
      hctbp_pkg::ST_FLUSH: cmd.flush_out = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/hctbp_datapath.sv
// Code table memories, bit accumulator and pending byte of the bit packer.
module hctbp_datapath #(
  parameter int SYMBOL_COUNT = hctbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hctbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  hctbp_pkg::item_t    item,
  input  hctbp_pkg::cmd_t     cmd,
  output hctbp_pkg::stat_t    stat,
  output hctbp_pkg::result_t  result,
  output logic                strobe
);

  localparam int IDX_W   = $clog2(SYMBOL_COUNT);
  localparam int LEN_CAP = (MAX_CODE_LEN < hctbp_pkg::CODE_W) ? MAX_CODE_LEN
                                                              : hctbp_pkg::CODE_W;
  localparam int ACC_W   = hctbp_pkg::ACC_W;

  logic [hctbp_pkg::CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [hctbp_pkg::LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0]      entry_valid;

  logic [IDX_W-1:0]             idx;
  logic                         in_range;
  logic [hctbp_pkg::LEN_W-1:0]  len_sat;
  logic [hctbp_pkg::CODE_W-1:0] code_rd;
  logic [hctbp_pkg::LEN_W-1:0]  len_rd;
  logic                         len_ok;
  logic [hctbp_pkg::LEN_W-1:0]  len_eff;

  logic [ACC_W-1:0]             mask_l;
  logic [ACC_W-1:0]             mask_p;
  logic [ACC_W-1:0]             code_f;
  logic [ACC_W-1:0]             acc_next;
  logic [hctbp_pkg::TOT_W-1:0]  total;

  logic [ACC_W-1:0]               acc;
  logic [hctbp_pkg::NBYTES_W-1:0] nbytes;
  logic [hctbp_pkg::CNT_W-1:0]    rem;
  logic [hctbp_pkg::BYTE_W-1:0]   pbyte;
  logic [hctbp_pkg::CNT_W-1:0]    pcount;

  assign idx      = item.symbol[IDX_W-1:0];
  assign in_range = ({1'b0, item.symbol} < 9'(SYMBOL_COUNT));
  assign len_sat  = (item.code_length > hctbp_pkg::LEN_W'(LEN_CAP))
                    ? hctbp_pkg::LEN_W'(LEN_CAP) : item.code_length;

  always_ff @(posedge clk) begin
    if (cmd.table_write && in_range) begin
      code_mem[idx] <= item.code_bits;
      len_mem[idx]  <= len_sat;
    end
    if (cmd.lookup) begin
      code_rd <= code_mem[idx];
      len_rd  <= len_mem[idx];
      len_ok  <= in_range && entry_valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.table_clear) begin
      entry_valid <= '0;
    end else if (cmd.table_write && in_range) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  // place the code above the pending bits, ones beyond the last code bit
  assign len_eff  = len_ok ? len_rd : '0;
  assign mask_l   = (ACC_W'(1) << len_eff) - ACC_W'(1);
  assign mask_p   = (ACC_W'(1) << pcount) - ACC_W'(1);
  assign code_f   = ({hctbp_pkg::FILL_BYTE, code_rd} & mask_l) | ~mask_l;
  assign acc_next = (code_f << pcount)
                    | ({{hctbp_pkg::CODE_W{1'b0}}, pbyte} & mask_p);
  assign total    = hctbp_pkg::TOT_W'(len_eff) + hctbp_pkg::TOT_W'(pcount);

  always_ff @(posedge clk) begin
    if (rst) begin
      nbytes <= '0;
    end else if (cmd.load) begin
      nbytes <= total[hctbp_pkg::TOT_W-1:3];
    end else if (cmd.emit) begin
      nbytes <= nbytes - hctbp_pkg::NBYTES_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc <= acc_next;
      rem <= total[2:0];
    end else if (cmd.emit) begin
      acc <= {hctbp_pkg::FILL_BYTE, acc[ACC_W-1:hctbp_pkg::BYTE_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbyte  <= hctbp_pkg::FILL_BYTE;
      pcount <= '0;
    end else if (cmd.commit) begin
      pbyte  <= acc[hctbp_pkg::BYTE_W-1:0];
      pcount <= rem;
    end else if (cmd.flush_out) begin
      pbyte  <= hctbp_pkg::FILL_BYTE;
      pcount <= '0;
    end
  end

  assign stat.bytes_zero = (nbytes == '0);

  assign strobe = cmd.emit || (cmd.flush_out && (pcount != '0));

  always_comb begin
    if (cmd.emit) begin
      result.out_byte   = acc[hctbp_pkg::BYTE_W-1:0];
      result.valid_bits = hctbp_pkg::VBITS_W'(hctbp_pkg::BYTE_W);
      result.last       = (nbytes == hctbp_pkg::NBYTES_W'(1));
    end else begin
      result.out_byte   = pbyte;
      result.valid_bits = hctbp_pkg::VBITS_W'(pcount);
      result.last       = 1'b1;
    end
  end

endmodule

FILE: rtl/huffman_code_table_bit_packer_core.sv
// Top level of the code table driven Huffman bit packer.
// Usage: present an item on item and raise start; the beat is taken at a rising
// edge where start is high and busy is low. Opcodes: clear table, write table
// entry, encode symbol, flush partial byte.
// Clear and write complete in the accept cycle and produce no result.
// Encode: the accept cycle reads the code table, the load state aligns the code
// with the pending bits, then each full byte appears on result for one cycle with
// strobe high, then the emit state stores the leftover bits once no full byte
// remains. An encode emits at most four bytes through the single accumulator,
// which shifts out one byte per cycle.
// Flush emits the partial byte with its bit count, if any.
// The result carrying last marks the final beat caused by an item.
// Results cannot be held off: strobe marks a beat that is taken at once.
// Reset clears all table valid flags, empties the pending byte (all ones, count
// zero) and returns the controller to idle; code entries stay undefined.
module huffman_code_table_bit_packer_core #(
  parameter int SYMBOL_COUNT = hctbp_pkg::SYMBOL_COUNT_DEF,
  parameter int MAX_CODE_LEN = hctbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  hctbp_pkg::item_t    item,
  output logic                busy,
  output logic                strobe,
  output hctbp_pkg::result_t  result
);

  hctbp_pkg::cmd_t  cmd;
  hctbp_pkg::stat_t stat;

  hctbp_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  hctbp_datapath #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .strobe (strobe)
  );

endmodule
